@@ rtl/mrpt_pkg.sv @@
// Shared constants, types and the witness base table for the primality tester.
package mrpt_pkg;

  localparam int DEFAULT_WIDTH = 16;
  localparam int NUM_BASES     = 12;
  localparam int BASE_W        = 6;
  localparam int BIDX_W        = 4;

  // Commands from the controller to the datapath
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SHIFT_D,
    CMD_INIT_BASE,
    CMD_MUL_R,
    CMD_MUL_A,
    CMD_SQR_X
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [BIDX_W-1:0] base_idx;
  } ctrl_t;

  typedef struct packed {
    logic lt2;
    logic is2;
    logic even;
    logic d_even;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic s_done;
    logic base_ge_n;
    logic mul_busy;
  } stat_t;

  function automatic logic [BASE_W-1:0] base_of(input logic [BIDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      4'd0:    b = 6'd2;
      4'd1:    b = 6'd3;
      4'd2:    b = 6'd5;
      4'd3:    b = 6'd7;
      4'd4:    b = 6'd11;
      4'd5:    b = 6'd13;
      4'd6:    b = 6'd17;
      4'd7:    b = 6'd19;
      4'd8:    b = 6'd23;
      4'd9:    b = 6'd29;
      4'd10:   b = 6'd31;
      4'd11:   b = 6'd37;
      default: b = 6'd63;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/miller_rabin_primality_test_top.sv @@
// Work per request: up to 12 bases x (2*WIDTH-s-1) modular multiplies, all on the
// bit-serial multiplier that every step shares.
// Throughput: one request at a time; the next is taken once the previous result has gone.
// Candidates below two, even ones and two itself are settled in S_CHECK without any multiply.
// Synchronous active-high reset clears the controller and the result valid flag.
module miller_rabin_primality_test_top #(
  parameter int WIDTH = mrpt_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [WIDTH-1:0] candidate,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             is_prime
);
  import mrpt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  mrpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .is_prime  (is_prime),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  mrpt_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cand_in (candidate),
    .ctrl    (ctrl),
    .stat    (stat)
  );

  // A stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_prime))
    else $error("result dropped while stalled");

  // No request is taken while a result waits
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("request accepted while result stalled");

  // A load only happens on an accepted request
  a_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.cmd == CMD_LOAD |-> in_valid && !in_stall)
    else $error("load without request");

endmodule

@@ rtl/mrpt_mulmod.sv @@
// Sequential modular multiplier: add-and-double over the bits of one operand.
module mrpt_mulmod #(
  parameter int WIDTH = mrpt_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic [WIDTH-1:0] n,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] p
);
  import mrpt_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] mb;
  logic [WIDTH-1:0] ma;
  logic [WIDTH-1:0] mn;
  logic [CW-1:0]    cnt;

  logic [WIDTH:0]   dbl;
  logic [WIDTH-1:0] dbl_r;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] acc_next;

  // Double the accumulator, reduce, then add a when the current bit is set
  always_comb begin
    dbl   = {acc, 1'b0};
    dbl_r = (dbl >= {1'b0, mn}) ? WIDTH'(dbl - {1'b0, mn}) : dbl[WIDTH-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, ma};
    if (mb[WIDTH-1])
      acc_next = (sum >= {1'b0, mn}) ? WIDTH'(sum - {1'b0, mn}) : sum[WIDTH-1:0];
    else
      acc_next = dbl_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      acc  <= '0;
      ma   <= a;
      mb   <= b;
      mn   <= n;
      cnt  <= CW'(WIDTH);
    end else if (busy) begin
      acc  <= acc_next;
      mb   <= {mb[WIDTH-2:0], 1'b0};
      cnt  <= cnt - 1'b1;
      done <= (cnt == CW'(1));
      if (cnt == CW'(1))
        busy <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  assign p = acc;

endmodule

@@ rtl/mrpt_datapath.sv @@
// Datapath: candidate, d, s, exponent, running values and the shared multiplier.
module mrpt_datapath #(
  parameter int WIDTH = mrpt_pkg::DEFAULT_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [WIDTH-1:0] cand_in,
  input  mrpt_pkg::ctrl_t  ctrl,
  output mrpt_pkg::stat_t  stat
);
  import mrpt_pkg::*;

  localparam int SW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] n;
  logic [WIDTH-1:0] d;
  logic [SW-1:0]    s;
  logic [SW-1:0]    j;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] ab;
  logic [WIDTH-1:0] nm1;

  logic             m_start;
  logic [WIDTH-1:0] m_a;
  logic [WIDTH-1:0] m_b;
  logic             m_busy;
  logic             m_done;
  logic [WIDTH-1:0] m_p;
  logic [WIDTH-1:0] base_w;
  logic [WIDTH:0]   base_x;
  logic [BASE_W-1:0] bval;

  assign nm1    = n - 1'b1;
  assign bval   = base_of(ctrl.base_idx);
  assign base_x = (WIDTH + 1)'(bval);
  assign base_w = base_x[WIDTH-1:0];

  // Pick multiplier operands for the command
  always_comb begin
    m_start = 1'b0;
    m_a     = r;
    m_b     = ab;
    case (ctrl.cmd)
      CMD_MUL_R: begin
        m_start = 1'b1;
      end
      CMD_MUL_A: begin
        m_start = 1'b1;
        m_a     = ab;
      end
      CMD_SQR_X: begin
        m_start = 1'b1;
        m_b     = r;
      end
      default: m_start = 1'b0;
    endcase
  end

  mrpt_mulmod #(.WIDTH(WIDTH)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (m_start),
    .a     (m_a),
    .b     (m_b),
    .n     (n),
    .busy  (m_busy),
    .done  (m_done),
    .p     (m_p)
  );

  // Track which register receives the product
  cmd_t pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= CMD_NONE;
    end else begin
      if (m_start)
        pend <= ctrl.cmd;
      case (ctrl.cmd)
        CMD_LOAD: begin
          n <= cand_in;
          d <= cand_in - 1'b1;
          s <= '0;
        end
        CMD_SHIFT_D: begin
          d <= d >> 1;
          s <= s + 1'b1;
        end
        CMD_INIT_BASE: begin
          e  <= d;
          r  <= WIDTH'(1);
          ab <= base_w;
          j  <= SW'(1);
        end
        CMD_MUL_A: e <= e >> 1;
        CMD_SQR_X: j <= j + 1'b1;
        default: ;
      endcase
      if (m_done) begin
        if (pend == CMD_MUL_A)
          ab <= m_p;
        else
          r <= m_p;
      end
    end
  end

  // Report conditions to the controller
  always_comb begin
    stat.lt2       = (n < WIDTH'(2));
    stat.is2       = (n == WIDTH'(2));
    stat.even      = ~n[0];
    stat.d_even    = ~d[0];
    stat.e_zero    = (e == '0);
    stat.e_lsb     = e[0];
    stat.x_one     = (r == WIDTH'(1));
    stat.x_nm1     = (r == nm1);
    stat.s_done    = (j >= s);
    stat.base_ge_n = (base_x >= {1'b0, n});
    stat.mul_busy  = m_busy | m_done;
  end

endmodule

@@ rtl/mrpt_ctrl.sv @@
// Controller: sequences decomposition, bases, exponentiation and squarings.
module mrpt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            is_prime,
  output mrpt_pkg::ctrl_t ctrl,
  input  mrpt_pkg::stat_t stat
);
  import mrpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DECOMP, S_BASE, S_INIT, S_EXP,
    S_EXPW, S_SQRW, S_TEST, S_SQR, S_SQRT, S_DONE
  } state_t;

  state_t            state;
  logic [BIDX_W-1:0] bidx;
  logic              pend_a;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_comb begin
    ctrl.base_idx = bidx;
    ctrl.cmd      = CMD_NONE;
    case (state)
      S_IDLE:   if (in_valid && !in_stall) ctrl.cmd = CMD_LOAD;
      S_DECOMP: if (stat.d_even) ctrl.cmd = CMD_SHIFT_D;
      S_INIT:   ctrl.cmd = CMD_INIT_BASE;
      S_EXP: begin
        if (!stat.e_zero && !stat.mul_busy)
          ctrl.cmd = stat.e_lsb ? CMD_MUL_R : CMD_MUL_A;
      end
      S_EXPW:   if (pend_a && !stat.mul_busy) ctrl.cmd = CMD_MUL_A;
      S_SQR:    ctrl.cmd = CMD_SQR_X;
      default:  ctrl.cmd = CMD_NONE;
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      is_prime  <= 1'b0;
      bidx      <= '0;
      pend_a    <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && !in_stall) state <= S_CHECK;
        S_CHECK: begin
          bidx <= '0;
          if (stat.lt2 || (stat.even && !stat.is2)) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else if (stat.is2) begin
            is_prime <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= S_DECOMP;
          end
        end
        S_DECOMP: if (!stat.d_even) state <= S_BASE;
        S_BASE: begin
          if (bidx == BIDX_W'(NUM_BASES) || stat.base_ge_n) begin
            is_prime <= 1'b1;
            state    <= S_DONE;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: state <= S_EXP;
        S_EXP: begin
          if (!stat.mul_busy) begin
            if (stat.e_zero) begin
              state <= S_TEST;
            end else begin
              pend_a <= stat.e_lsb;
              state  <= S_EXPW;
            end
          end
        end
        // Follow a multiply into r with the squaring of the base
        S_EXPW: begin
          if (!stat.mul_busy) begin
            if (pend_a) pend_a <= 1'b0;
            else state <= S_EXP;
          end
        end
        S_TEST: begin
          if (stat.x_one || stat.x_nm1) begin
            bidx  <= bidx + 1'b1;
            state <= S_BASE;
          end else if (stat.s_done) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else begin
            state <= S_SQR;
          end
        end
        S_SQR:  state <= S_SQRW;
        S_SQRW: if (!stat.mul_busy) state <= S_SQRT;
        S_SQRT: begin
          if (stat.x_nm1) begin
            bidx  <= bidx + 1'b1;
            state <= S_BASE;
          end else if (stat.x_one || stat.s_done) begin
            is_prime <= 1'b0;
            state    <= S_DONE;
          end else begin
            state <= S_SQR;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
